// File: sv/psc_pkg.sv
`default_nettype none
package psc_pkg;

  localparam int MAX_VERTS_DEF  = 16;
  localparam int COORD_BITS_DEF = 16;

  // push = d * a * 2^QShift / |a|^2
  localparam int QShift = 12;
  localparam int PushW  = 32;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_OVF   = 2'd1;
  localparam logic [1:0] ERR_EMPTY = 2'd2;

  typedef enum logic [3:0] {
    S_LOAD,
    S_EDGE,
    S_WAIT,
    S_MUL,
    S_DGO,
    S_DIV,
    S_SQ,
    S_PICK,
    S_SG1,
    S_SG2,
    S_SG3,
    S_OUT
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic signed [PushW-1:0] neg_sat(input logic signed [PushW-1:0] v);
    logic signed [PushW-1:0] r;
    if (v == {1'b1, {(PushW-1){1'b0}}}) r = {1'b0, {(PushW-1){1'b1}}};
    else r = -v;
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/psc_in_if.sv
`default_nettype none
interface psc_in_if #(
  parameter int CoordBits = 16
);
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic signed [CoordBits-1:0] vert_x;
  logic signed [CoordBits-1:0] vert_y;
  logic                        last;

  modport source (output valid, mode, vert_x, vert_y, last, input ready);
  modport sink   (input valid, mode, vert_x, vert_y, last, output ready);
endinterface
`default_nettype wire

// File: sv/psc_out_if.sv
`default_nettype none
interface psc_out_if;
  logic               valid;
  logic               ready;
  logic               collides;
  logic signed [31:0] push_x;
  logic signed [31:0] push_y;
  logic [1:0]         error;

  modport source (output valid, collides, push_x, push_y, error, input ready);
  modport sink   (input valid, collides, push_x, push_y, error, output ready);
endinterface
`default_nettype wire

// File: sv/psc_cell.sv
`default_nettype none
module psc_cell #(
  parameter int CoordBits = psc_pkg::COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic signed [CoordBits-1:0]   wr_x_i,
  input  logic signed [CoordBits-1:0]   wr_y_i,
  input  logic                          en_i,
  input  logic signed [CoordBits:0]     ax_i,
  input  logic signed [CoordBits:0]     ay_i,
  input  logic                          seen_i,
  input  logic signed [2*CoordBits+1:0] lo_i,
  input  logic signed [2*CoordBits+1:0] hi_i,
  output logic signed [CoordBits:0]     ax_o,
  output logic signed [CoordBits:0]     ay_o,
  output logic                          seen_o,
  output logic signed [2*CoordBits+1:0] lo_o,
  output logic signed [2*CoordBits+1:0] hi_o,
  output logic signed [CoordBits-1:0]   vx_o,
  output logic signed [CoordBits-1:0]   vy_o
);
  import psc_pkg::*;

  localparam int AW = CoordBits + 1;
  localparam int DW = 2 * CoordBits + 2;

  logic signed [CoordBits-1:0] vx_q, vy_q;
  logic signed [AW-1:0]        ax_q, ay_q;
  logic signed [2*CoordBits:0] mx, my;
  logic signed [DW-1:0]        dot_d, dot_q;
  logic signed [DW-1:0]        lo_d, lo_q, hi_d, hi_q;
  logic                        seen_d, seen_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      vx_q <= wr_x_i;
      vy_q <= wr_y_i;
    end
  end

  assign mx    = vx_q * ax_i;
  assign my    = vy_q * ay_i;
  assign dot_d = DW'(mx) + DW'(my);

  // the running interval is fed from the product register, so it lags the axis passed to the next cell
  always_comb begin
    seen_d = seen_i;
    lo_d   = lo_i;
    hi_d   = hi_i;
    if (en_i) begin
      seen_d = 1'b1;
      if (!seen_i) begin
        lo_d = dot_q;
        hi_d = dot_q;
      end else begin
        lo_d = (dot_q < lo_i) ? dot_q : lo_i;
        hi_d = (dot_q > hi_i) ? dot_q : hi_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else begin
      seen_q <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q  <= ax_i;
    ay_q  <= ay_i;
    dot_q <= dot_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
  end

  assign ax_o   = ax_q;
  assign ay_o   = ay_q;
  assign seen_o = seen_q;
  assign lo_o   = lo_q;
  assign hi_o   = hi_q;
  assign vx_o   = vx_q;
  assign vy_o   = vy_q;
endmodule
`default_nettype wire

// File: sv/psc_div.sv
`default_nettype none
module psc_div #(
  parameter int NumW = 64,
  parameter int DenW = 34
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [NumW-1:0]          num_i,
  input  logic [DenW-1:0]          den_i,
  output psc_pkg::div_stat_t       stat_o,
  output logic [psc_pkg::PushW-1:0] quo_o
);
  import psc_pkg::*;

  localparam int QW = PushW;
  localparam int SW = $clog2(QW);
  localparam logic [QW-1:0] QCap = {1'b1, {(QW-1){1'b0}}};

  logic [DenW:0]   rem_q;
  logic [DenW+1:0] trial;
  logic [QW-1:0]   low_q, quo_q;
  logic [SW-1:0]   step_q;
  logic            ovf_q, busy_q, done_q;

  assign trial = {rem_q, low_q[QW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + SW'(1);
      if (step_q == SW'(QW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // high part above the quotient window: at or above the divisor means the quotient
  // does not fit and clips anyway
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ovf_q <= ((DenW+1)'(num_i[NumW-1:QW]) >= (DenW+1)'(den_i));
      rem_q <= (DenW+1)'(num_i[NumW-1:QW]);
      low_q <= num_i[QW-1:0];
      quo_q <= '0;
    end else if (busy_q) begin
      low_q <= {low_q[QW-2:0], 1'b0};
      if (trial >= (DenW+2)'(den_i)) begin
        rem_q <= (DenW+1)'(trial - (DenW+2)'(den_i));
        quo_q <= {quo_q[QW-2:0], 1'b1};
      end else begin
        rem_q <= trial[DenW:0];
        quo_q <= {quo_q[QW-2:0], 1'b0};
      end
    end
  end

  assign quo_o       = (ovf_q || (quo_q > QCap)) ? QCap : quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
endmodule
`default_nettype wire

// File: sv/polygon_sat_collision_unit.sv
// Loading: one vertex per cycle; ready is high while the unit collects vertices.
// Test after the last vertex: edges of A, then of B, are walked; each usable axis goes
// through the cell rows and then a 32-step divider, and sign states S_SG1 to S_SG3
// follow. A separating axis ends the test early. One pair is tested at a time.
// Reset is asynchronous, active low: clears counts, sums, state and output valid;
// stored vertex coordinates hold no reset value.
`default_nettype none
module polygon_sat_collision_unit #(
  parameter int MaxVerts  = psc_pkg::MAX_VERTS_DEF,
  parameter int CoordBits = psc_pkg::COORD_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  psc_in_if.sink    vert_i,
  psc_out_if.source res_o
);
  import psc_pkg::*;

  localparam int AW = CoordBits + 1;
  localparam int DW = 2 * CoordBits + 2;
  localparam int LW = 2 * AW;
  localparam int MW = DW + 1 + AW;
  localparam int NW = MW + QShift;
  localparam int IW = $clog2(MaxVerts);
  localparam int CW = $clog2(MaxVerts + 1);
  localparam int RW = $clog2(MaxVerts + 2);
  localparam int WW = $clog2(MaxVerts + 3);
  localparam int SW = CoordBits + CW;
  localparam int XW = SW + CW + 2;
  localparam int PW = XW + PushW;
  localparam logic signed [PushW-1:0] PosMax = {1'b0, {(PushW-1){1'b1}}};

  state_e state_q, state_d;

  // load bookkeeping
  logic [CW-1:0]        cnt_a_q, cnt_b_q, cnt_a_d, cnt_b_d, cnt_sel;
  logic                 ovf_q, ovf_d, room, in_acc, wr_ok;
  logic signed [SW-1:0] sax_q, say_q, sbx_q, sby_q;

  // edge walk
  logic                        poly_q;
  logic [RW-1:0]               r_q;
  logic [CW-1:0]               n_cur;
  logic [IW-1:0]               rd_idx;
  logic                        edge_end;
  logic signed [CoordBits-1:0] cur_x, cur_y, prev_x_q, prev_y_q;
  logic signed [AW-1:0]        ax_n, ay_n, axq_q, ayq_q;
  logic                        axis_nz;
  logic [WW-1:0]               wcnt_q;
  logic                        wait_done;

  // cell rows, index 0 is polygon A
  logic signed [AW-1:0]        lk_ax [2][MaxVerts+1];
  logic signed [AW-1:0]        lk_ay [2][MaxVerts+1];
  logic                        lk_seen [2][MaxVerts+1];
  logic signed [DW-1:0]        lk_lo [2][MaxVerts+1];
  logic signed [DW-1:0]        lk_hi [2][MaxVerts+1];
  logic signed [CoordBits-1:0] vx [2][MaxVerts];
  logic signed [CoordBits-1:0] vy [2][MaxVerts];

  // per-axis arithmetic
  logic                       overlap;
  logic signed [DW:0]         da, db;
  logic [DW:0]                d_q;
  logic [AW-1:0]              magx_q, magy_q;
  logic                       sgnx_q, sgny_q;
  logic [MW-1:0]              numx_q, numy_q;
  logic signed [LW-1:0]       sqa, sqb;
  logic [LW-1:0]              len2_q;
  logic                       div_start;
  div_stat_t                  stx, sty;
  logic [PushW-1:0]           qx, qy;
  logic signed [PushW-1:0]    px_n, py_n, px_q, py_q;
  logic signed [2*PushW-1:0]  sqx_n, sqy_n;
  logic [2*PushW-1:0]         sqx_q, sqy_q, sq_sum, best_q;
  logic                       have_q;

  // result staging and sign test
  logic signed [PushW-1:0] best_px_q, best_py_q;
  logic                    coll_q;
  logic [1:0]              err_q;
  logic signed [XW-1:0]    dx_q, dy_q;
  logic signed [PW-1:0]    dpx_q, dpy_q;
  logic signed [PW:0]      dsum;

  // output register
  logic                    ov_q, oc_q;
  logic signed [PushW-1:0] opx_q, opy_q;
  logic [1:0]              oerr_q;
  logic                    out_free;

  assign in_acc  = vert_i.valid & vert_i.ready;
  assign cnt_sel = vert_i.mode ? cnt_b_q : cnt_a_q;
  assign room    = cnt_sel < CW'(MaxVerts);
  assign wr_ok   = in_acc & room;
  assign cnt_a_d = cnt_a_q + CW'(wr_ok & ~vert_i.mode);
  assign cnt_b_d = cnt_b_q + CW'(wr_ok & vert_i.mode);
  assign ovf_d   = ovf_q | (in_acc & ~room);

  for (genvar p = 0; p < 2; p++) begin : g_row
    assign lk_ax[p][0]   = axq_q;
    assign lk_ay[p][0]   = ayq_q;
    assign lk_seen[p][0] = 1'b0;
    assign lk_lo[p][0]   = '0;
    assign lk_hi[p][0]   = '0;
    for (genvar k = 0; k < MaxVerts; k++) begin : g_cell
      psc_cell #(.CoordBits(CoordBits)) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .wr_en_i (wr_ok && (vert_i.mode == 1'(p)) && (cnt_sel == CW'(k))),
        .wr_x_i  (vert_i.vert_x),
        .wr_y_i  (vert_i.vert_y),
        .en_i    (((p == 1) ? cnt_b_q : cnt_a_q) > CW'(k)),
        .ax_i    (lk_ax[p][k]),
        .ay_i    (lk_ay[p][k]),
        .seen_i  (lk_seen[p][k]),
        .lo_i    (lk_lo[p][k]),
        .hi_i    (lk_hi[p][k]),
        .ax_o    (lk_ax[p][k+1]),
        .ay_o    (lk_ay[p][k+1]),
        .seen_o  (lk_seen[p][k+1]),
        .lo_o    (lk_lo[p][k+1]),
        .hi_o    (lk_hi[p][k+1]),
        .vx_o    (vx[p][k]),
        .vy_o    (vy[p][k])
      );
    end
  end

  // edge i runs from vertex i to vertex i+1, wrapping to 0
  assign n_cur    = poly_q ? cnt_b_q : cnt_a_q;
  assign rd_idx   = (r_q == RW'(n_cur)) ? '0 : r_q[IW-1:0];
  assign edge_end = (r_q == RW'(n_cur) + RW'(1));
  assign cur_x    = vx[poly_q][rd_idx];
  assign cur_y    = vy[poly_q][rd_idx];
  assign ax_n     = AW'(cur_y) - AW'(prev_y_q);
  assign ay_n     = AW'(prev_x_q) - AW'(cur_x);
  assign axis_nz  = (ax_n != '0) || (ay_n != '0);

  assign wait_done = (wcnt_q == WW'(MaxVerts + 2)) &&
                     (lk_ax[0][MaxVerts] == axq_q) && (lk_ay[0][MaxVerts] == ayq_q) &&
                     (lk_ax[1][MaxVerts] == axq_q) && (lk_ay[1][MaxVerts] == ayq_q);

  assign overlap = lk_seen[0][MaxVerts] && lk_seen[1][MaxVerts] &&
                   (lk_hi[0][MaxVerts] >= lk_lo[1][MaxVerts]) &&
                   (lk_hi[1][MaxVerts] >= lk_lo[0][MaxVerts]);
  assign da = (DW+1)'(lk_hi[1][MaxVerts]) - (DW+1)'(lk_lo[0][MaxVerts]);
  assign db = (DW+1)'(lk_hi[0][MaxVerts]) - (DW+1)'(lk_lo[1][MaxVerts]);

  assign sqa = axq_q * axq_q;
  assign sqb = ayq_q * ayq_q;

  psc_div #(.NumW(NW), .DenW(LW)) u_divx (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({numx_q, {QShift{1'b0}}}),
    .den_i   (len2_q),
    .stat_o  (stx),
    .quo_o   (qx)
  );

  psc_div #(.NumW(NW), .DenW(LW)) u_divy (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({numy_q, {QShift{1'b0}}}),
    .den_i   (len2_q),
    .stat_o  (sty),
    .quo_o   (qy)
  );

  // magnitude quotient gets the axis sign; positive side clips one below 2^31
  assign px_n = sgnx_q ? PushW'(-$signed({1'b0, qx}))
                       : ((qx > PushW'(PosMax)) ? PosMax : $signed(qx));
  assign py_n = sgny_q ? PushW'(-$signed({1'b0, qy}))
                       : ((qy > PushW'(PosMax)) ? PosMax : $signed(qy));
  assign sqx_n  = px_q * px_q;
  assign sqy_n  = py_q * py_q;
  assign sq_sum = sqx_q + sqy_q;
  assign dsum   = (PW+1)'(dpx_q) + (PW+1)'(dpy_q);
  assign out_free = !ov_q || res_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_LOAD: begin
        if (in_acc && vert_i.last) begin
          if (ovf_d || cnt_a_d == '0 || cnt_b_d == '0) state_d = S_OUT;
          else state_d = S_EDGE;
        end
      end
      S_EDGE: begin
        if (edge_end) begin
          if (poly_q) state_d = S_SG1;
        end else if (r_q != '0 && axis_nz) begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: if (wait_done) state_d = overlap ? S_MUL : S_OUT;
      S_MUL:  state_d = S_DGO;
      S_DGO:  state_d = S_DIV;
      S_DIV:  if (stx.done && sty.done) state_d = S_SQ;
      S_SQ:   state_d = S_PICK;
      S_PICK: state_d = S_EDGE;
      S_SG1:  state_d = S_SG2;
      S_SG2:  state_d = S_SG3;
      S_SG3:  state_d = S_OUT;
      S_OUT:  if (out_free) state_d = S_LOAD;
      default: state_d = S_LOAD;
    endcase
  end

  // handshake and unit controls
  always_comb begin
    vert_i.ready = (state_q == S_LOAD);
    div_start    = (state_q == S_DGO);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_a_q <= '0;
      cnt_b_q <= '0;
      ovf_q   <= 1'b0;
      sax_q   <= '0;
      say_q   <= '0;
      sbx_q   <= '0;
      sby_q   <= '0;
      poly_q  <= 1'b0;
      r_q     <= '0;
      wcnt_q  <= '0;
      have_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_LOAD: begin
          cnt_a_q <= cnt_a_d;
          cnt_b_q <= cnt_b_d;
          ovf_q   <= ovf_d;
          if (wr_ok && !vert_i.mode) begin
            sax_q <= sax_q + SW'(vert_i.vert_x);
            say_q <= say_q + SW'(vert_i.vert_y);
          end
          if (wr_ok && vert_i.mode) begin
            sbx_q <= sbx_q + SW'(vert_i.vert_x);
            sby_q <= sby_q + SW'(vert_i.vert_y);
          end
          poly_q <= 1'b0;
          r_q    <= '0;
          have_q <= 1'b0;
        end
        S_EDGE: begin
          if (edge_end) begin
            poly_q <= 1'b1;
            r_q    <= '0;
          end else begin
            r_q    <= r_q + RW'(1);
            wcnt_q <= '0;
          end
        end
        S_WAIT: if (!wait_done) wcnt_q <= wcnt_q + WW'(1);
        S_PICK: if (!have_q || sq_sum < best_q) have_q <= 1'b1;
        S_OUT: begin
          if (out_free) begin
            cnt_a_q <= '0;
            cnt_b_q <= '0;
            ovf_q   <= 1'b0;
            sax_q   <= '0;
            say_q   <= '0;
            sbx_q   <= '0;
            sby_q   <= '0;
          end
        end
        default: ;
      endcase
      if (state_q == S_OUT && out_free) ov_q <= 1'b1;
      else if (res_o.ready) ov_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_LOAD: begin
        coll_q    <= 1'b0;
        best_px_q <= '0;
        best_py_q <= '0;
        if (ovf_d) err_q <= ERR_OVF;
        else if (cnt_a_d == '0 || cnt_b_d == '0) err_q <= ERR_EMPTY;
        else err_q <= ERR_OK;
      end
      S_EDGE: begin
        if (!edge_end) begin
          prev_x_q <= cur_x;
          prev_y_q <= cur_y;
          if (r_q != '0 && axis_nz) begin
            axq_q <= ax_n;
            ayq_q <= ay_n;
          end
        end
      end
      S_WAIT: begin
        if (wait_done) begin
          if (!overlap) begin
            best_px_q <= '0;
            best_py_q <= '0;
          end
          d_q    <= (da < db) ? $unsigned(da) : $unsigned(db);
          sgnx_q <= axq_q[AW-1];
          sgny_q <= ayq_q[AW-1];
          magx_q <= axq_q[AW-1] ? AW'(-axq_q) : AW'(axq_q);
          magy_q <= ayq_q[AW-1] ? AW'(-ayq_q) : AW'(ayq_q);
        end
      end
      S_MUL: begin
        numx_q <= MW'(d_q) * MW'(magx_q);
        numy_q <= MW'(d_q) * MW'(magy_q);
        len2_q <= LW'($unsigned(sqa)) + LW'($unsigned(sqb));
      end
      S_DIV: begin
        px_q <= px_n;
        py_q <= py_n;
      end
      S_SQ: begin
        sqx_q <= $unsigned(sqx_n);
        sqy_q <= $unsigned(sqy_n);
      end
      S_PICK: begin
        if (!have_q || sq_sum < best_q) begin
          best_q    <= sq_sum;
          best_px_q <= px_q;
          best_py_q <= py_q;
        end
      end
      S_SG1: begin
        dx_q <= XW'(sax_q) * XW'($signed({1'b0, cnt_b_q}))
              - XW'(sbx_q) * XW'($signed({1'b0, cnt_a_q}));
        dy_q <= XW'(say_q) * XW'($signed({1'b0, cnt_b_q}))
              - XW'(sby_q) * XW'($signed({1'b0, cnt_a_q}));
      end
      S_SG2: begin
        dpx_q <= PW'(dx_q) * PW'(best_px_q);
        dpy_q <= PW'(dy_q) * PW'(best_py_q);
      end
      S_SG3: begin
        coll_q <= 1'b1;
        err_q  <= ERR_OK;
        if (dsum > (PW+1)'(0)) begin
          best_px_q <= neg_sat(best_px_q);
          best_py_q <= neg_sat(best_py_q);
        end
      end
      S_OUT: begin
        if (out_free) begin
          oc_q   <= coll_q;
          opx_q  <= best_px_q;
          opy_q  <= best_py_q;
          oerr_q <= err_q;
        end
      end
      default: ;
    endcase
  end

  assign res_o.valid    = ov_q;
  assign res_o.collides = oc_q;
  assign res_o.push_x   = opx_q;
  assign res_o.push_y   = opy_q;
  assign res_o.error    = oerr_q;
endmodule
`default_nettype wire

// File: sv/psc_checker.sv
`default_nettype none
module psc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_last_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_collides_i,
  input logic [31:0] out_push_x_i,
  input logic [31:0] out_push_y_i,
  input logic [1:0]  out_error_i
);
  import psc_pkg::*;

  // a last vertex starts the test, so the next cycle takes no vertex
  a_last_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && in_last_i) |=> !in_ready_i)
    else $error("vertex taken right after the closing vertex");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_error_i != ERR_OK) |->
      (!out_collides_i && out_push_x_i == '0 && out_push_y_i == '0))
    else $error("error result with collision or push");

  a_nocoll_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_collides_i) |-> (out_push_x_i == '0 && out_push_y_i == '0))
    else $error("push reported without collision");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> ($stable(out_push_x_i) && $stable(out_push_y_i)))
    else $error("stalled result changed");
endmodule

bind polygon_sat_collision_unit psc_checker u_psc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (vert_i.valid),
  .in_ready_i     (vert_i.ready),
  .in_last_i      (vert_i.last),
  .out_valid_i    (res_o.valid),
  .out_ready_i    (res_o.ready),
  .out_collides_i (res_o.collides),
  .out_push_x_i   (res_o.push_x),
  .out_push_y_i   (res_o.push_y),
  .out_error_i    (res_o.error)
);
`default_nettype wire
